// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define TTT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that also holds while reset is asserted.
`define TTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg
// Types, constants and register codes of the tunneling temperature tracker.
// ----------------------------------------------------------------------------
package ttt_pkg;

	localparam int WINDOW_MAX_DEF = 1024;

	localparam int SAMPLE_W = 16;
	localparam int BETA_W   = 32;
	localparam int GAIN_W   = 16;
	localparam int WLEN_W   = 11;
	localparam int LG_W     = 5;
	localparam int T_W      = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Beta is Q12.20; 1.0 is 2^20
	localparam logic [BETA_W-1:0] BETA_ONE = 32'd1048576;
	// 0.03 in Q0.16, truncated
	localparam logic [SAMPLE_W-1:0] MEAN_OFFSET = 16'd1966;
	localparam logic [LG_W-1:0] LG_MAX = 5'd16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BETA_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LOG2   = 2'd2;

	// Input transaction modes
	localparam logic MODE_SAMPLE  = 1'b0;
	localparam logic MODE_RESTART = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd1024;
	localparam logic [LG_W-1:0]   LG_RESET   = 5'd10;

	typedef struct packed {
		logic                mode;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [BETA_W-1:0]   beta;
		logic [SAMPLE_W-1:0] mean_sample;
	} out_item_t;

	// Commands from the sequencer to the sample window
	typedef struct packed {
		logic start;
		logic clear;
	} win_ctrl_t;

endpackage

// File: rtl/ttt_window.sv
// ----------------------------------------------------------------------------
// ttt_window
// Sample ring memory with running sum, fill count and write index.
// ----------------------------------------------------------------------------
module ttt_window #(
	parameter int WINDOW_MAX = ttt_pkg::WINDOW_MAX_DEF,
	localparam int CNTW = $clog2(WINDOW_MAX + 1),
	localparam int SUMW = ttt_pkg::SAMPLE_W + CNTW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ttt_pkg::win_ctrl_t            ctrl,
	input  logic [ttt_pkg::SAMPLE_W-1:0]  sample,
	input  logic [CNTW-1:0]               win_len,
	output logic [SUMW-1:0]               sum,
	output logic [CNTW-1:0]               count,
	output logic                          done
);
	import ttt_pkg::*;

	localparam int IDXW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	logic [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
	logic [SAMPLE_W-1:0] rdata_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [IDXW-1:0]     idx_s1;
	logic                pend_q;
	logic                done_q;
	logic [IDXW-1:0]     wr_idx_q;
	logic [CNTW-1:0]     count_q;
	logic [SUMW-1:0]     sum_q;

	logic [IDXW-1:0] rd_idx;
	logic [CNTW-1:0] nxt_idx;
	logic            full;

	assign rd_idx  = (CNTW'(wr_idx_q) >= win_len) ? '0 : wr_idx_q;
	assign nxt_idx = CNTW'(idx_s1) + CNTW'(1);
	assign full    = (count_q >= win_len);

	// Read the slot to be replaced on start, write the new sample in the following cycle
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rdata_q   <= ring_mem[rd_idx];
			idx_s1    <= rd_idx;
			sample_s1 <= sample;
		end
		if (pend_q && !ctrl.clear) begin
			ring_mem[idx_s1] <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 1'b0;
			done_q   <= 1'b0;
			wr_idx_q <= '0;
			count_q  <= '0;
			sum_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.clear) begin
				pend_q   <= 1'b0;
				wr_idx_q <= '0;
				count_q  <= '0;
				sum_q    <= '0;
			end else begin
				pend_q <= ctrl.start;
				if (pend_q) begin
					// drop the oldest sample once the window is full
					sum_q <= sum_q - (full ? SUMW'(rdata_q) : '0) + SUMW'(sample_s1);
					if (!full) begin
						count_q <= count_q + CNTW'(1);
					end
					wr_idx_q <= (nxt_idx >= win_len) ? '0 : IDXW'(nxt_idx);
					done_q   <= 1'b1;
				end
			end
		end
	end

	assign sum   = sum_q;
	assign count = count_q;
	assign done  = done_q;

endmodule

// File: rtl/ttt_div.sv
// ----------------------------------------------------------------------------
// ttt_div
// Restoring divider, one quotient bit per cycle, for the rolling mean.
// ----------------------------------------------------------------------------
module ttt_div #(
	parameter int WINDOW_MAX = ttt_pkg::WINDOW_MAX_DEF,
	localparam int CNTW = $clog2(WINDOW_MAX + 1),
	localparam int SUMW = ttt_pkg::SAMPLE_W + CNTW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [SUMW-1:0]               dividend,
	input  logic [CNTW-1:0]               divisor,
	output logic [ttt_pkg::SAMPLE_W-1:0]  quotient,
	output logic                          done
);
	import ttt_pkg::*;

	localparam int QW   = SAMPLE_W;
	localparam int STPW = $clog2(QW + 1);

	logic [CNTW-1:0] rem_q;
	logic [CNTW-1:0] dsr_q;
	logic [QW-1:0]   dvd_q;
	logic [QW-1:0]   quo_q;
	logic [STPW-1:0] step_q;
	logic            busy_q;
	logic            done_q;

	logic [CNTW:0] trial;
	logic [CNTW:0] diff;

	assign trial = {rem_q, dvd_q[QW-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STPW'(QW);
			end else if (busy_q) begin
				step_q <= step_q - STPW'(1);
				if (step_q == STPW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The sum stays below count * 2^16, so the upper part starts below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SUMW-1:QW];
			dvd_q <= dividend[QW-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[QW-2:0], 1'b0};
			if (!diff[CNTW]) begin
				rem_q <= diff[CNTW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNTW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// File: rtl/ttt_beta.sv
// ----------------------------------------------------------------------------
// ttt_beta
// Beta register and its update through one shared multiplier, one product
// per step.
// ----------------------------------------------------------------------------
module ttt_beta (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          restart,
	input  logic [ttt_pkg::T_W-1:0]       t,
	input  logic [ttt_pkg::SAMPLE_W-1:0]  mean,
	input  logic [ttt_pkg::GAIN_W-1:0]    gain,
	output logic [ttt_pkg::BETA_W-1:0]    beta,
	output logic                          done
);
	import ttt_pkg::*;

	localparam int MA_W = 32;
	localparam int MB_W = 26;
	localparam int P_W  = MA_W + MB_W;
	localparam int DM_W = 25;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_TT   = 3'd1;
	localparam logic [2:0] B_MG   = 3'd2;
	localparam logic [2:0] B_MGT  = 3'd3;
	localparam logic [2:0] B_M    = 3'd4;
	localparam logic [2:0] B_BM   = 3'd5;
	localparam logic [2:0] B_SAT  = 3'd6;

	logic [2:0]          step_q;
	logic [BETA_W-1:0]   beta_q;
	logic                done_q;
	logic [T_W-1:0]      t_q;
	logic [T_W-1:0]      t2_q;
	logic [SAMPLE_W-1:0] mag_q;
	logic                neg_q;
	logic                zero_q;
	logic [MB_W-1:0]     m_q;
	logic [P_W-1:0]      prod_q;

	logic [MA_W-1:0]  mul_a;
	logic [MB_W-1:0]  mul_b;
	logic [P_W-1:0]   prod;
	logic [DM_W-1:0]  dmag;
	logic [P_W-21:0]  nb;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			B_TT: begin
				mul_a = MA_W'(t_q);
				mul_b = MB_W'(t_q);
			end
			B_MG: begin
				mul_a = MA_W'(mag_q);
				mul_b = MB_W'(gain);
			end
			B_MGT: begin
				mul_a = prod_q[MA_W-1:0];
				mul_b = MB_W'(t2_q);
			end
			B_BM: begin
				mul_a = beta_q;
				mul_b = m_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = P_W'(mul_a) * P_W'(mul_b);
	assign dmag = prod_q[48:24];
	assign nb   = prod_q[P_W-1:20];

	always_ff @(posedge clk) begin
		prod_q <= prod;
		if (start) begin
			t_q   <= t;
			neg_q <= (mean < MEAN_OFFSET);
			mag_q <= (mean < MEAN_OFFSET) ? (MEAN_OFFSET - mean) : (mean - MEAN_OFFSET);
		end
		if (step_q == B_MG) begin
			t2_q <= prod_q[32:16];
		end
		if (step_q == B_M) begin
			zero_q <= neg_q && ({1'b0, dmag} >= MB_W'(BETA_ONE));
			m_q    <= neg_q ? (MB_W'(BETA_ONE) - MB_W'(dmag)) : (MB_W'(BETA_ONE) + MB_W'(dmag));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= B_IDLE;
			beta_q <= BETA_ONE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (restart) begin
				step_q <= B_IDLE;
				beta_q <= BETA_ONE;
			end else begin
				case (step_q)
					B_IDLE: begin
						if (start) begin
							step_q <= B_TT;
						end
					end
					B_TT:  step_q <= B_MG;
					B_MG:  step_q <= B_MGT;
					B_MGT: step_q <= B_M;
					B_M:   step_q <= B_BM;
					B_BM: begin
						// multiplier collapsed to zero or below: beta clamps at zero
						if (zero_q) begin
							beta_q <= '0;
							done_q <= 1'b1;
							step_q <= B_IDLE;
						end else begin
							step_q <= B_SAT;
						end
					end
					B_SAT: begin
						beta_q <= (|nb[P_W-21:BETA_W]) ? '1 : nb[BETA_W-1:0];
						done_q <= 1'b1;
						step_q <= B_IDLE;
					end
					default: step_q <= B_IDLE;
				endcase
			end
		end
	end

	assign beta = beta_q;
	assign done = done_q;

endmodule

// File: rtl/tunneling_temperature_tracker_core.sv
// ----------------------------------------------------------------------------
// tunneling_temperature_tracker_core
// Adaptive inverse temperature for stochastic tunneling.
// ----------------------------------------------------------------------------
// Each transaction on the input channel either restarts the tracker (mode 1)
// or adds a Q0.16 sample to a rolling window held in a single-port ring
// memory, and yields one result: beta in Q12.20 and the window mean. A sample
// transaction goes through the ring read and write-back, the bit-serial mean
// divider, the beta update through one shared 32x26 multiplier (shorter
// when beta clamps to zero) and the load of the output register. The next
// transaction is accepted once that load has taken place; the load waits
// while an older result is held under out_stall. A restart goes straight to
// the output load. One transaction is worked at a time; a finished result
// waits in the output register while the next transaction is accepted.
// Writing window_length empties the window; write configuration only while
// the block is idle.
// ----------------------------------------------------------------------------
module tunneling_temperature_tracker_core #(
	parameter int WINDOW_MAX = ttt_pkg::WINDOW_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  ttt_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ttt_pkg::out_item_t              out_data,
	input  logic                            cfg_we,
	input  logic [ttt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ttt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ttt_pkg::*;

	localparam int CNTW = $clog2(WINDOW_MAX + 1);
	localparam int SUMW = SAMPLE_W + CNTW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WIN  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_BETA = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [WLEN_W-1:0]   wlen_q;
	logic [LG_W-1:0]     lg_q;
	logic [SAMPLE_W-1:0] phase_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic                out_valid_q;
	out_item_t           out_data_q;

	logic            in_take;
	logic            restart;
	win_ctrl_t       win_ctrl;
	logic [CNTW-1:0] win_len;
	logic [SUMW-1:0] win_sum;
	logic [CNTW-1:0] win_count;
	logic            win_done;
	logic [SAMPLE_W-1:0] quo;
	logic            div_done;
	logic [BETA_W-1:0] beta;
	logic            beta_done;
	logic [LG_W-1:0] lg_eff;
	logic [T_W-1:0]  period;
	logic [T_W-1:0]  phase_m;
	logic [T_W-1:0]  t_val;
	logic            out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign restart  = in_take && (in_data.mode == MODE_RESTART);

	assign win_ctrl.start = in_take && (in_data.mode == MODE_SAMPLE);
	assign win_ctrl.clear = restart || (cfg_we && (cfg_index == CFG_WINDOW_LENGTH));

	// Out-of-range window length: zero acts as one, large values clip
	always_comb begin
		if (wlen_q == '0) begin
			win_len = CNTW'(1);
		end else if (32'(wlen_q) > 32'(WINDOW_MAX)) begin
			win_len = CNTW'(WINDOW_MAX);
		end else begin
			win_len = CNTW'(wlen_q);
		end
	end

	// t = (P - phase) << (16 - log2 P), exact in Q1.16
	assign lg_eff  = (lg_q > LG_MAX) ? LG_MAX : lg_q;
	assign period  = T_W'(1) << lg_eff;
	assign phase_m = T_W'(phase_q) & (period - T_W'(1));
	assign t_val   = (period - phase_m) << (LG_MAX - lg_eff);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			wlen_q <= WLEN_RESET;
			lg_q   <= LG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BETA_GAIN:     gain_q <= cfg_data[GAIN_W-1:0];
				CFG_WINDOW_LENGTH: wlen_q <= cfg_data[WLEN_W-1:0];
				CFG_PERIOD_LOG2:   lg_q   <= cfg_data[LG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (restart) begin
						phase_q <= '0;
						state_q <= ST_OUT;
					end else if (in_take) begin
						phase_q <= phase_q + SAMPLE_W'(1);
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					if (win_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_BETA;
					end
				end
				ST_BETA: begin
					if (beta_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (restart) begin
			mean_q <= '0;
		end else if (div_done) begin
			mean_q <= quo;
		end
		if (out_load) begin
			out_data_q.beta        <= beta;
			out_data_q.mean_sample <= mean_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	ttt_window #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (win_ctrl),
		.sample  (in_data.sample),
		.win_len (win_len),
		.sum     (win_sum),
		.count   (win_count),
		.done    (win_done)
	);

	ttt_div #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (win_done),
		.dividend (win_sum),
		.divisor  (win_count),
		.quotient (quo),
		.done     (div_done)
	);

	ttt_beta u_beta (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_done),
		.restart (restart),
		.t       (t_val),
		.mean    (quo),
		.gain    (gain_q),
		.beta    (beta),
		.done    (beta_done)
	);

endmodule

// File: rtl/ttt_checker.sv
// ----------------------------------------------------------------------------
// ttt_checker
// Port-level checks of the tracker core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttt_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  ttt_pkg::out_item_t   out_data
);
	import ttt_pkg::*;

	logic [1:0] open_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Count transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (in_acc && !out_acc) begin
			open_q <= open_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			open_q <= open_q - 2'd1;
		end
	end

	`TTT_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |-> !out_valid, "result valid during reset")
	`TTT_ASSERT(a_one_at_a_time, clk, arst_n, in_acc |=> in_stall, "second transaction taken while busy")
	`TTT_ASSERT(a_no_invented, clk, arst_n, out_valid |-> (open_q != 2'd0), "result without a transaction")
	`TTT_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "result dropped under stall")
	`TTT_ASSERT(a_out_stable, clk, arst_n, out_valid && out_stall |=> $stable(out_data), "result changed under stall")

endmodule

bind tunneling_temperature_tracker_core ttt_checker u_ttt_checker (.*);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tunneling temperature tracker core.
// ----------------------------------------------------------------------------
// Drives sample and restart transactions through the valid/stall input channel
// and compares every result (beta, rolling mean) against a cycle-free
// predictor of the tracker kept inside the bench. Directed tests cover the
// reset settings, field extremes and register corner values. Random phases
// then cover window wrap-around, beta saturation and decay to zero under
// varied settings. Random idle gaps and output stalls apply outside calm phases.
// ----------------------------------------------------------------------------
module tb_top;
	import ttt_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int TIMEOUT_CYCLES = 750_000;
	localparam int DRAIN_CYCLES   = 40;

	typedef longint unsigned u64_t;
	typedef enum int {PROF_NEAR, PROF_LOW, PROF_ANY, PROF_HIGH, PROF_EDGE, PROF_FLOOR} profile_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Tracker state mirrored by the predictor
	logic [GAIN_W-1:0]   gain_reg;
	logic [WLEN_W-1:0]   wlen_reg;
	logic [LG_W-1:0]     lg_reg;
	logic [SAMPLE_W-1:0] ring_mem [WINDOW_MAX_DEF];
	int                  ring_wr;
	int                  fill_cnt;
	u64_t                win_sum;
	logic [15:0]         phase_cnt;
	logic [BETA_W-1:0]   beta_st;

	out_item_t beta_expect_q[$];
	int        err_cnt;
	bit        calm;
	int        stall_hold;

	tunneling_temperature_tracker_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_W-1:0] draw_sample(profile_t p);
		case (p)
			PROF_NEAR:  return 16'($urandom_range(1700, 2300));
			PROF_LOW:   return 16'($urandom_range(0, 4000));
			PROF_HIGH:  return 16'($urandom_range(60000, 65535));
			PROF_EDGE:  return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			PROF_FLOOR: return 16'($urandom_range(0, 200));
			default:    return 16'($urandom);
		endcase
	endfunction

	function automatic void drop_window();
		ring_wr  = 0;
		fill_cnt = 0;
		win_sum  = '0;
	endfunction

	// Advance the tracker by one transaction and return the beta/mean it yields
	function automatic out_item_t step_tracker(in_item_t it);
		out_item_t           res;
		int                  w;
		int                  idx;
		int                  lg;
		logic [SAMPLE_W-1:0] mean;
		u64_t                period, ph, t, t2, mag, dmag, nb;
		longint              diff, m;
		if (it.mode == MODE_RESTART) begin
			beta_st = BETA_ONE;
			drop_window();
			phase_cnt = '0;
			res.beta = BETA_ONE;
			res.mean_sample = '0;
			return res;
		end
		w = (wlen_reg == 0) ? 1 : ((wlen_reg > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(wlen_reg));
		idx = (ring_wr >= w) ? 0 : ring_wr;
		// full window: retire the oldest sample before overwriting it
		if (fill_cnt >= w)
			win_sum -= ring_mem[idx];
		else
			fill_cnt++;
		ring_mem[idx] = it.sample;
		win_sum += it.sample;
		ring_wr = (idx + 1 >= w) ? 0 : idx + 1;
		mean = SAMPLE_W'(win_sum / u64_t'(fill_cnt));

		phase_cnt = phase_cnt + 16'd1;
		lg = (lg_reg > LG_MAX) ? int'(LG_MAX) : int'(lg_reg);
		period = u64_t'(1) << lg;
		ph = u64_t'(phase_cnt) & (period - 1);
		t = (period - ph) << (16 - lg);
		t2 = (t * t) >> 16;

		diff = longint'(mean) - longint'(MEAN_OFFSET);
		mag = (diff < 0) ? u64_t'(-diff) : u64_t'(diff);
		dmag = (mag * u64_t'(gain_reg) * t2) >> 24;
		m = (diff < 0) ? longint'(BETA_ONE) - longint'(dmag) : longint'(BETA_ONE) + longint'(dmag);
		if (m <= 0) begin
			beta_st = '0;
		end else begin
			nb = (u64_t'(beta_st) * u64_t'(m)) >> 20;
			beta_st = (nb > 64'hFFFF_FFFF) ? '1 : BETA_W'(nb);
		end
		res.beta = beta_st;
		res.mean_sample = mean;
		return res;
	endfunction

	task automatic send_item(input logic mode, input logic [SAMPLE_W-1:0] smp);
		in_item_t it;
		int       gap;
		it.mode = mode;
		it.sample = smp;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		beta_expect_q.push_back(step_tracker(it));
	endtask

	// Write one register once every pending result has drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		while (beta_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BETA_GAIN: gain_reg = val[GAIN_W-1:0];
			CFG_WINDOW_LENGTH: begin
				wlen_reg = val[WLEN_W-1:0];
				drop_window();
			end
			CFG_PERIOD_LOG2: lg_reg = val[LG_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_config(input logic [GAIN_W-1:0] g, input logic [WLEN_W-1:0] wl,
			input logic [LG_W-1:0] lg);
		write_reg(CFG_BETA_GAIN, CFG_DATA_W'(g));
		write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(wl));
		write_reg(CFG_PERIOD_LOG2, CFG_DATA_W'(lg));
	endtask

	task automatic test_reset_config();
		send_item(MODE_SAMPLE, 16'h0000);
		send_item(MODE_SAMPLE, 16'hFFFF);
		send_item(MODE_SAMPLE, MEAN_OFFSET);
		send_item(MODE_SAMPLE, MEAN_OFFSET - 16'd1);
		send_item(MODE_SAMPLE, MEAN_OFFSET + 16'd1);
		send_item(MODE_RESTART, 16'hFFFF);
		send_item(MODE_SAMPLE, 16'h8000);
	endtask

	task automatic test_register_extremes();
		// max gain, single-sample window, period of one: saturate beta
		write_config(16'hFFFF, 11'd1, 5'd0);
		repeat (5) send_item(MODE_SAMPLE, 16'hFFFF);
		repeat (2) send_item(MODE_SAMPLE, 16'h0000);
		send_item(MODE_RESTART, 16'h5A5A);
		// zero gain holds beta; zero window acts as one; oversized log2 clamps
		write_config(16'd0, 11'd0, 5'd31);
		send_item(MODE_SAMPLE, 16'hFFFF);
		send_item(MODE_SAMPLE, 16'h0001);
		// oversized window clamps to the ring depth
		write_config(16'd1, 11'd2047, LG_MAX);
		send_item(MODE_SAMPLE, MEAN_OFFSET);
		send_item(MODE_SAMPLE, 16'd40000);
	endtask

	task automatic test_window_wrap();
		int k;
		calm = 1'b0;
		write_config(16'($urandom_range(1, 4096)), 11'($urandom_range(200, 300)),
			5'($urandom_range(8, 16)));
		send_item(MODE_RESTART, 16'($urandom));
		for (k = 0; k < 320; k++)
			send_item(MODE_SAMPLE, draw_sample(PROF_NEAR));
	endtask

	task automatic test_random_phases();
		int                n, run, k, p, r;
		profile_t          prof;
		logic [GAIN_W-1:0] g;
		logic [WLEN_W-1:0] wl;
		logic [LG_W-1:0]   lg;
		for (p = 0; p < 10; p++) begin
			calm = ($urandom_range(0, 3) == 0);
			case (p)
				0: begin g = 16'hFFFF; wl = 11'd4;    lg = 5'd0;  end
				1: begin g = 16'hFFFF; wl = 11'd1;    lg = 5'd31; end
				2: begin g = 16'd0;    wl = 11'd2047; lg = LG_MAX; end
				3: begin g = 16'd1;    wl = 11'd1024; lg = 5'd0;  end
				default: begin
					r = $urandom_range(0, 9);
					g = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 16384));
					r = $urandom_range(0, 9);
					wl = (r == 0) ? 11'd0 : (r == 1) ? 11'd2047 :
						(r < 4) ? 11'($urandom_range(1, 1024)) : 11'($urandom_range(1, 40));
					lg = 5'($urandom_range(0, 31));
				end
			endcase
			write_config(g, wl, lg);
			n = 0;
			while (n < 45) begin
				send_item(MODE_RESTART, 16'($urandom));
				n++;
				// first phase: long runs of tiny samples drive beta down to zero
				run = (p == 0) ? 40 : $urandom_range(1, 40);
				prof = (p == 0) ? PROF_FLOOR : profile_t'($urandom_range(0, 5));
				for (k = 0; k < run; k++) begin
					if ($urandom_range(0, 99) < 4)
						send_item(MODE_RESTART, 16'($urandom));
					else
						send_item(MODE_SAMPLE, draw_sample(prof));
				end
				n += run;
			end
		end
		calm = 1'b0;
	endtask

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
		end else if (calm || $urandom_range(0, 1) == 0) begin
			out_stall <= 1'b0;
			stall_hold = $urandom_range(0, 8);
		end else begin
			out_stall <= 1'b1;
			stall_hold = pick_gap();
		end
	end

	// Results are stable by the falling edge; a transaction seen here completes at the next rise
	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (beta_expect_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected result: expected none, got beta %h mean %h",
					$time, out_data.beta, out_data.mean_sample);
			end else begin
				want = beta_expect_q.pop_front();
				if (out_data.beta !== want.beta) begin
					err_cnt++;
					$display("%0t: beta mismatch: expected %h, got %h",
						$time, want.beta, out_data.beta);
				end
				if (out_data.mean_sample !== want.mean_sample) begin
					err_cnt++;
					$display("%0t: mean_sample mismatch: expected %h, got %h",
						$time, want.mean_sample, out_data.mean_sample);
				end
			end
		end
	end

	initial begin
		int n;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		calm = 1'b0;
		err_cnt = 0;
		stall_hold = 0;
		gain_reg = GAIN_RESET;
		wlen_reg = WLEN_RESET;
		lg_reg = LG_RESET;
		drop_window();
		phase_cnt = '0;
		beta_st = BETA_ONE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_register_extremes();
		test_window_wrap();
		test_random_phases();

		in_valid <= 1'b0;
		for (n = 0; n < TIMEOUT_CYCLES && beta_expect_q.size() != 0; n++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && beta_expect_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
